// File: hw/rtl/assert_macros.svh
// Assertion helpers for the RTL files (included by pfe_back)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that the consequent holds in the cycle after the antecedent, outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/pfe_pkg.sv
`default_nettype none
package pfe_pkg;
  localparam int unsigned StackDepthDefault = 64;
  localparam int unsigned FracDigitsDefault = 4;
  localparam int unsigned WordW = 48;
  localparam int unsigned CharW = 8;
  localparam int unsigned StatW = 3;

  localparam logic [WordW-1:0] MaxPos = 48'h7FFF_FFFF_FFFF;
  localparam logic [WordW-1:0] MaxNeg = 48'h8000_0000_0000;

  localparam logic [CharW-1:0] ChHash = 8'h23;
  localparam logic [CharW-1:0] ChEq = 8'h3D;
  localparam logic [CharW-1:0] ChDot = 8'h2E;
  localparam logic [CharW-1:0] ChPlus = 8'h2B;
  localparam logic [CharW-1:0] ChMinus = 8'h2D;
  localparam logic [CharW-1:0] ChStar = 8'h2A;
  localparam logic [CharW-1:0] ChSlash = 8'h2F;
  localparam logic [CharW-1:0] ChZero = 8'h30;
  localparam logic [CharW-1:0] ChNine = 8'h39;
  localparam logic [CharW-1:0] ChNl = 8'h0A;

  typedef enum logic [StatW-1:0] {
    ST_NONE = 3'd0, ST_RESULT = 3'd1, ST_BYE = 3'd2, ST_EMPTY = 3'd3,
    ST_FULL = 3'd4, ST_DIVZ = 3'd5, ST_OVF = 3'd6
  } status_t;

  // Operation passed from the front to the back
  typedef enum logic [2:0] {
    OP_NONE, OP_PUSH, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_POP, OP_BYE
  } op_t;

  // One queued command: optional number push, then an action
  typedef struct packed {
    logic             push_num;
    logic [WordW-1:0] num;
    op_t              op;
    logic             halt_nl;
  } cmd_t;

  function automatic logic [15:0] frac_weight(input logic [1:0] idx);
    case (idx)
      2'd0: frac_weight = 16'd6554;
      2'd1: frac_weight = 16'd655;
      2'd2: frac_weight = 16'd66;
      default: frac_weight = 16'd7;
    endcase
  endfunction
endpackage
`default_nettype wire

// File: hw/rtl/postfix_expression_evaluator_top.sv
`default_nettype none
// Postfix calculator taking one ASCII character per beat and returning one result
// beat per character (value, status). Numbers are Q31.16 on a stack in block memory.
// Division uses a restoring divider that makes one quotient bit per cycle over 64
// quotient bits; a divide by zero leaves it at once. A full stack or a halted block
// answers straight from idle. A two-entry queue takes the next characters while
// one is evaluated. After '#' and the end of its line, every character returns
// status 0 until reset.
module postfix_expression_evaluator_top #(
  parameter int unsigned STACK_DEPTH = pfe_pkg::StackDepthDefault,
  parameter int unsigned FRACTION_DIGITS = pfe_pkg::FracDigitsDefault
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [pfe_pkg::CharW-1:0] in_char_code,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed [pfe_pkg::WordW-1:0] out_value,
  output logic [pfe_pkg::StatW-1:0]      out_status
);
  pfe_pkg::cmd_t f_cmd, q_cmd;
  logic          f_valid, f_ready, q_valid, q_ready;
  logic [pfe_pkg::WordW-1:0] val;

  pfe_front #(.FRAC_DIGITS(FRACTION_DIGITS)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_char_code,
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
  );
  pfe_fifo u_fifo (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
  );
  pfe_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk, .rst_n, .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .out_valid, .out_ready, .out_value(val), .out_status
  );
  assign out_value = val;
endmodule
`default_nettype wire

// File: hw/rtl/pfe_front.sv
`default_nettype none
// Classify characters, build numbers and emit commands for the back end
module pfe_front #(
  parameter int unsigned FRAC_DIGITS = pfe_pkg::FracDigitsDefault
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [pfe_pkg::CharW-1:0] in_char_code,
  output logic                           cmd_valid,
  input  wire logic                      cmd_ready,
  output pfe_pkg::cmd_t                  cmd
);
  logic [pfe_pkg::WordW-1:0] acc_r, acc_nxt;
  logic                      bld_r, bld_nxt, frac_r, frac_nxt;
  logic [2:0]                fcnt_r, fcnt_nxt;
  logic [3:0]                dig;
  logic [pfe_pkg::WordW+3:0] ten;
  logic [pfe_pkg::WordW:0]   fsum;
  logic                      is_dig;

  assign in_ready = cmd_ready;
  assign dig = 4'(in_char_code - pfe_pkg::ChZero);
  assign is_dig = (in_char_code >= pfe_pkg::ChZero) && (in_char_code <= pfe_pkg::ChNine);
  assign ten = {4'd0, acc_r} * 52'd10 + {32'd0, dig, 16'd0};
  assign fsum = {1'b0, acc_r} + 49'(dig * pfe_pkg::frac_weight(fcnt_r[1:0]));

  // Decode one character
  always_comb begin
    acc_nxt = acc_r; bld_nxt = bld_r; frac_nxt = frac_r; fcnt_nxt = fcnt_r;
    cmd.push_num = 1'b0; cmd.num = acc_r; cmd.op = pfe_pkg::OP_NONE; cmd.halt_nl = 1'b0;
    if (is_dig) begin
      if (!bld_r) begin
        bld_nxt = 1'b1; frac_nxt = 1'b0; fcnt_nxt = '0;
        acc_nxt = {28'd0, dig, 16'd0};
      end else if (!frac_r) begin
        acc_nxt = (ten > 52'(pfe_pkg::MaxPos)) ? pfe_pkg::MaxPos : ten[47:0];
      end else if (fcnt_r < 3'(FRAC_DIGITS)) begin
        acc_nxt = (fsum > 49'(pfe_pkg::MaxPos)) ? pfe_pkg::MaxPos : fsum[47:0];
        fcnt_nxt = fcnt_r + 3'd1;
      end
    end else if (in_char_code == pfe_pkg::ChDot && bld_r && !frac_r) begin
      frac_nxt = 1'b1;
    end else begin
      if (bld_r) begin
        cmd.push_num = 1'b1;
        bld_nxt = 1'b0; frac_nxt = 1'b0; fcnt_nxt = '0; acc_nxt = '0;
      end
      case (in_char_code)
        pfe_pkg::ChPlus:  cmd.op = pfe_pkg::OP_ADD;
        pfe_pkg::ChMinus: cmd.op = pfe_pkg::OP_SUB;
        pfe_pkg::ChStar:  cmd.op = pfe_pkg::OP_MUL;
        pfe_pkg::ChSlash: cmd.op = pfe_pkg::OP_DIV;
        pfe_pkg::ChEq:    cmd.op = pfe_pkg::OP_POP;
        pfe_pkg::ChHash:  cmd.op = pfe_pkg::OP_BYE;
        default:          cmd.op = pfe_pkg::OP_NONE;
      endcase
      // Mark a newline; the back end tracks goodbye and halts on it
      cmd.halt_nl = (in_char_code == pfe_pkg::ChNl);
    end
  end
  assign cmd_valid = in_valid;

  // Hold number builder state, advance on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0; bld_r <= 1'b0; frac_r <= 1'b0; fcnt_r <= '0;
    end else if (in_valid && in_ready) begin
      acc_r <= acc_nxt; bld_r <= bld_nxt; frac_r <= frac_nxt; fcnt_r <= fcnt_nxt;
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/pfe_fifo.sv
`default_nettype none
// Two-entry queue between front and back
module pfe_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_valid,
  output logic               wr_ready,
  input  pfe_pkg::cmd_t      wr_data,
  output logic               rd_valid,
  input  wire logic          rd_ready,
  output pfe_pkg::cmd_t      rd_data
);
  pfe_pkg::cmd_t mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data = mem_r[rp_r];

  // Advance pointers on each beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (wr_valid && wr_ready) begin
        mem_r[wp_r] <= wr_data; wp_r <= ~wp_r;
      end
      if (rd_valid && rd_ready) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/pfe_back.sv
`default_nettype none
`include "assert_macros.svh"
// Execute commands on the operand stack; iterative divider, split multiplier
module pfe_back #(
  parameter int unsigned STACK_DEPTH = pfe_pkg::StackDepthDefault
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cmd_valid,
  output logic                           cmd_ready,
  input  pfe_pkg::cmd_t                  cmd,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [pfe_pkg::WordW-1:0]      out_value,
  output logic [pfe_pkg::StatW-1:0]      out_status
);
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned W = pfe_pkg::WordW;

  typedef enum logic [3:0] {
    S_IDLE, S_RD1, S_RD2, S_EXEC, S_MUL1, S_MUL2, S_DIV, S_FIN, S_POP, S_OUT
  } state_t;

  state_t             st_r;
  logic [W-1:0]       mem [STACK_DEPTH];
  logic [DW-1:0]      dep_r;
  pfe_pkg::cmd_t      c_r;
  logic [W-1:0]       rd_r, r_r, l_r;
  logic [AW-1:0]      raddr;
  logic               rd_en;
  logic [W-1:0]       ma_r, mb_r;
  logic               neg_r;
  logic [47:0]        hi_r, mid_r, lo_r;
  logic [57:0]        mul_sum;
  logic [W+15:0]      num_r;
  logic [W:0]         rem_r;
  logic [W+15:0]      q_r;
  logic [6:0]         it_r;
  logic [W:0]         mag_r;
  logic [W-1:0]       res_r, ov_r;
  logic [pfe_pkg::StatW-1:0] sta_r, ost_r;
  logic               quit_r, halted_r;
  logic [W:0]         sum_w, trial;
  logic [W:0]         lim;
  logic               ovf_w;

  assign cmd_ready = (st_r == S_IDLE) && !out_valid;
  assign out_value = ov_r;
  assign out_status = ost_r;
  assign lim = neg_r ? {1'b0, pfe_pkg::MaxNeg} : {1'b0, pfe_pkg::MaxPos};
  assign ovf_w = mag_r > lim;
  assign trial = {rem_r[W-1:0], num_r[W+15]} - {1'b0, mb_r};

  // Synchronous stack read
  always_comb begin
    rd_en = (st_r == S_RD1) || (st_r == S_RD2);
    raddr = AW'(dep_r - ((st_r == S_RD2) ? DW'(2) : DW'(1)));
  end
  always_ff @(posedge clk) begin
    if (rd_en) rd_r <= mem[raddr];
  end

  assign sum_w = (c_r.op == pfe_pkg::OP_ADD) ? {l_r[W-1], l_r} + {r_r[W-1], r_r}
                                             : {l_r[W-1], l_r} - {r_r[W-1], r_r};

  // Combine the partial products of the magnitude product, shifted down by 16
  assign mul_sum = 58'({hi_r, 32'd0}) + 58'({({1'b0, mid_r} + {1'b0, q_r[W-1:0]}), 8'd0})
                   + 58'(lo_r >> 16);

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; dep_r <= '0; out_valid <= 1'b0; quit_r <= 1'b0; halted_r <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (st_r)
        S_IDLE: if (cmd_valid && cmd_ready) begin
          c_r <= cmd;
          sta_r <= pfe_pkg::ST_NONE;
          if (halted_r) begin
            // Answer every character with value 0 and status none once halted
            ov_r <= '0; ost_r <= pfe_pkg::ST_NONE; out_valid <= 1'b1;
          end else if (cmd.push_num) begin
            if (dep_r == DW'(STACK_DEPTH)) begin
              ov_r <= '0; ost_r <= pfe_pkg::ST_FULL; out_valid <= 1'b1;
            end else begin
              mem[AW'(dep_r)] <= cmd.num;
              dep_r <= dep_r + DW'(1);
              st_r <= S_RD1;
            end
          end else st_r <= S_RD1;
        end
        S_RD1: begin
          case (c_r.op)
            pfe_pkg::OP_ADD, pfe_pkg::OP_SUB, pfe_pkg::OP_MUL, pfe_pkg::OP_DIV:
              if (dep_r < DW'(2)) begin
                ov_r <= '0; ost_r <= pfe_pkg::ST_EMPTY; st_r <= S_OUT;
              end else st_r <= S_RD2;
            pfe_pkg::OP_POP:
              if (dep_r == '0) begin
                ov_r <= '0; ost_r <= pfe_pkg::ST_EMPTY; st_r <= S_OUT;
              end else begin
                dep_r <= dep_r - DW'(1); st_r <= S_POP;
              end
            pfe_pkg::OP_BYE: begin
              quit_r <= 1'b1;
              ov_r <= '0; ost_r <= pfe_pkg::ST_BYE; st_r <= S_OUT;
            end
            default: begin
              if (c_r.halt_nl && quit_r) halted_r <= 1'b1;
              ov_r <= '0; ost_r <= pfe_pkg::ST_NONE; st_r <= S_OUT;
            end
          endcase
        end
        S_RD2: begin r_r <= rd_r; st_r <= S_EXEC; end
        S_EXEC: begin
          l_r <= rd_r;
          dep_r <= dep_r - DW'(2);
          neg_r <= rd_r[W-1] ^ r_r[W-1];
          ma_r <= rd_r[W-1] ? -rd_r : rd_r;
          mb_r <= r_r[W-1] ? -r_r : r_r;
          case (c_r.op)
            pfe_pkg::OP_MUL: st_r <= S_MUL1;
            pfe_pkg::OP_DIV: begin
              num_r <= {rd_r[W-1] ? -rd_r : rd_r, 16'd0};
              rem_r <= '0; q_r <= '0; it_r <= 7'd64;
              st_r <= S_DIV;
            end
            default: st_r <= S_FIN;
          endcase
        end
        S_MUL1: begin
          hi_r <= 48'(ma_r[47:24] * mb_r[47:24]);
          mid_r <= 48'(ma_r[47:24] * mb_r[23:0]);
          lo_r <= 48'(ma_r[23:0] * mb_r[23:0]);
          q_r <= {16'd0, 48'(ma_r[23:0] * mb_r[47:24])};
          st_r <= S_MUL2;
        end
        S_MUL2: begin
          if (hi_r >= 48'h8000) mag_r <= {1'b0, pfe_pkg::MaxNeg} + 49'd1;
          else mag_r <= (mul_sum[57:W] != '0) ? {1'b1, {W{1'b0}}} : {1'b0, mul_sum[W-1:0]};
          st_r <= S_FIN;
          sta_r <= pfe_pkg::ST_OVF;
        end
        S_DIV: begin
          if (mb_r == '0) begin
            res_r <= l_r[W-1] ? pfe_pkg::MaxNeg : ((l_r == '0) ? '0 : pfe_pkg::MaxPos);
            sta_r <= pfe_pkg::ST_DIVZ; c_r.op <= pfe_pkg::OP_NONE; st_r <= S_FIN;
          end else if (it_r == '0) begin
            mag_r <= (q_r[W+15:W] != '0) ? {1'b1, 48'd0} : {1'b0, q_r[W-1:0]};
            sta_r <= pfe_pkg::ST_OVF; st_r <= S_FIN;
          end else begin
            if (!trial[W]) begin
              rem_r <= trial; q_r <= {q_r[W+14:0], 1'b1};
            end else begin
              rem_r <= {rem_r[W-1:0], num_r[W+15]}; q_r <= {q_r[W+14:0], 1'b0};
            end
            num_r <= {num_r[W+14:0], 1'b0};
            it_r <= it_r - 7'd1;
          end
        end
        S_FIN: begin
          if (c_r.op == pfe_pkg::OP_ADD || c_r.op == pfe_pkg::OP_SUB) begin
            neg_r <= sum_w[W];
            mag_r <= sum_w[W] ? -sum_w : sum_w;
            c_r.op <= pfe_pkg::OP_MUL;
            sta_r <= pfe_pkg::ST_OVF;
          end else begin
            if (sta_r == pfe_pkg::ST_DIVZ) begin
              mem[AW'(dep_r)] <= res_r; ost_r <= pfe_pkg::ST_DIVZ;
            end else begin
              if (ovf_w) mem[AW'(dep_r)] <= neg_r ? pfe_pkg::MaxNeg : pfe_pkg::MaxPos;
              else mem[AW'(dep_r)] <= neg_r ? -mag_r[W-1:0] : mag_r[W-1:0];
              ost_r <= ovf_w ? pfe_pkg::ST_OVF : pfe_pkg::ST_NONE;
            end
            ov_r <= '0;
            dep_r <= dep_r + DW'(1);
            st_r <= S_OUT;
          end
        end
        S_POP: begin
          ov_r <= rd_r; ost_r <= pfe_pkg::ST_RESULT; st_r <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1; st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_depth_max, clk, rst_n, 1'b1, dep_r <= DW'(STACK_DEPTH))
  `ASSERT_IMPL(a_busy_no_out, clk, rst_n, st_r != S_IDLE, !cmd_ready)
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status))
endmodule
`default_nettype wire

// File: dv/postfix_expression_evaluator_top_test.sv
`default_nettype none
module postfix_expression_evaluator_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = pfe_pkg::StackDepthDefault;
  localparam int unsigned FracDigits = pfe_pkg::FracDigitsDefault;

  typedef struct packed {
    logic [pfe_pkg::WordW-1:0] value;
    logic [pfe_pkg::StatW-1:0] status;
  } calc_result_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [pfe_pkg::CharW-1:0] in_char_code;
  logic out_valid;
  logic out_ready;
  logic signed [pfe_pkg::WordW-1:0] out_value;
  logic [pfe_pkg::StatW-1:0] out_status;

  postfix_expression_evaluator_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_char_code(in_char_code),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_value(out_value), .out_status(out_status)
  );

  // Predictor state
  logic [pfe_pkg::WordW-1:0] operand_mem [Depth];
  int unsigned stack_used;
  logic [63:0] num_acc;
  bit building;
  bit in_frac;
  int unsigned frac_cnt;
  bit quit_seen;
  bit halted;

  calc_result_t pending_results[$];
  logic [pfe_pkg::CharW-1:0] char_queue[$];
  int unsigned errors;
  int unsigned chars_sent;
  int unsigned results_seen;
  int unsigned hold_left;
  bit hold_done;

  function automatic logic [pfe_pkg::WordW-1:0] saturate(input bit neg,
                                                         input logic [63:0] mag,
                                                         inout bit ovf);
    logic [63:0] lim;
    lim = neg ? 64'(pfe_pkg::MaxNeg) : 64'(pfe_pkg::MaxPos);
    if (mag > lim) begin
      mag = lim;
      ovf = 1'b1;
    end
    return neg ? pfe_pkg::WordW'(-mag) : mag[pfe_pkg::WordW-1:0];
  endfunction

  function automatic logic [63:0] magnitude(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [15:0] weight_of(input int unsigned idx);
    case (idx)
      0: return 16'd6554;
      1: return 16'd655;
      2: return 16'd66;
      default: return 16'd7;
    endcase
  endfunction

  // Evaluate one character against the predictor state
  task automatic eval_char(input logic [pfe_pkg::CharW-1:0] c, output calc_result_t r);
    logic [63:0] d;
    logic [63:0] n;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] mag;
    logic [63:0] hi;
    logic [127:0] prod;
    longint lv;
    longint rv;
    longint s;
    logic [pfe_pkg::WordW-1:0] res;
    bit ovf;
    bit dz;
    r = '0;
    ovf = 1'b0;
    dz = 1'b0;
    if (halted) return;
    if (c >= pfe_pkg::ChZero && c <= pfe_pkg::ChNine) begin
      d = 64'(c - pfe_pkg::ChZero);
      if (!building) begin
        building = 1'b1;
        in_frac = 1'b0;
        frac_cnt = 0;
        num_acc = d << 16;
      end else if (!in_frac) begin
        n = num_acc * 10 + (d << 16);
        num_acc = n > 64'(pfe_pkg::MaxPos) ? 64'(pfe_pkg::MaxPos) : n;
      end else if (frac_cnt < FracDigits) begin
        n = num_acc + d * weight_of(frac_cnt);
        num_acc = n > 64'(pfe_pkg::MaxPos) ? 64'(pfe_pkg::MaxPos) : n;
        frac_cnt++;
      end
      return;
    end
    if (c == pfe_pkg::ChDot && building && !in_frac) begin
      in_frac = 1'b1;
      return;
    end
    // End a number in progress and push it
    if (building) begin
      building = 1'b0;
      in_frac = 1'b0;
      frac_cnt = 0;
      if (stack_used >= Depth) begin
        num_acc = 0;
        r.status = pfe_pkg::ST_FULL;
        return;
      end
      operand_mem[stack_used] = num_acc[pfe_pkg::WordW-1:0];
      stack_used++;
      num_acc = 0;
    end
    if (c == pfe_pkg::ChPlus || c == pfe_pkg::ChMinus || c == pfe_pkg::ChStar ||
        c == pfe_pkg::ChSlash) begin
      if (stack_used < 2) begin
        r.status = pfe_pkg::ST_EMPTY;
        return;
      end
      rv = longint'(signed'(operand_mem[stack_used-1]));
      lv = longint'(signed'(operand_mem[stack_used-2]));
      stack_used -= 2;
      if (c == pfe_pkg::ChPlus || c == pfe_pkg::ChMinus) begin
        s = (c == pfe_pkg::ChPlus) ? lv + rv : lv - rv;
        res = saturate(s < 0, magnitude(s), ovf);
      end else if (c == pfe_pkg::ChStar) begin
        ma = magnitude(lv);
        mb = magnitude(rv);
        hi = (ma >> 24) * (mb >> 24);
        prod = 128'(ma) * 128'(mb);
        mag = (hi >= 64'h8000) ? 64'(pfe_pkg::MaxNeg) + 1 : prod[79:16];
        res = saturate((lv < 0) != (rv < 0), mag, ovf);
      end else if (rv == 0) begin
        dz = 1'b1;
        res = lv > 0 ? pfe_pkg::MaxPos : (lv < 0 ? pfe_pkg::MaxNeg : '0);
      end else begin
        mag = (magnitude(lv) << 16) / magnitude(rv);
        res = saturate((lv < 0) != (rv < 0), mag, ovf);
      end
      operand_mem[stack_used] = res;
      stack_used++;
      if (dz) r.status = pfe_pkg::ST_DIVZ;
      else if (ovf) r.status = pfe_pkg::ST_OVF;
      return;
    end
    if (c == pfe_pkg::ChEq) begin
      if (stack_used == 0) begin
        r.status = pfe_pkg::ST_EMPTY;
        return;
      end
      stack_used--;
      r.value = operand_mem[stack_used];
      r.status = pfe_pkg::ST_RESULT;
      return;
    end
    if (c == pfe_pkg::ChHash) begin
      quit_seen = 1'b1;
      r.status = pfe_pkg::ST_BYE;
      return;
    end
    if (c == pfe_pkg::ChNl && quit_seen) halted = 1'b1;
  endtask

  task automatic add_text(input string s);
    foreach (s[i]) char_queue.push_back(s[i]);
  endtask

  // Random number with optional fraction; rarely long enough to saturate
  task automatic add_number();
    int unsigned ndig;
    ndig = ($urandom_range(99) < 5) ? 16 : $urandom_range(1, 4);
    repeat (ndig) char_queue.push_back(8'(pfe_pkg::ChZero + $urandom_range(9)));
    if ($urandom_range(99) < 30) begin
      char_queue.push_back(pfe_pkg::ChDot);
      repeat ($urandom_range(6)) char_queue.push_back(8'(pfe_pkg::ChZero + $urandom_range(9)));
    end
  endtask

  task automatic add_operator();
    case ($urandom_range(3))
      0: char_queue.push_back(pfe_pkg::ChPlus);
      1: char_queue.push_back(pfe_pkg::ChMinus);
      2: char_queue.push_back(pfe_pkg::ChStar);
      default: char_queue.push_back(pfe_pkg::ChSlash);
    endcase
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Build the character stream
  initial begin
    logic [pfe_pkg::CharW-1:0] noise;
    int unsigned pick;
    bit overfill_done;
    rst_n = 1'b0;
    stack_used = 0;
    num_acc = 0;
    building = 1'b0;
    in_frac = 1'b0;
    frac_cnt = 0;
    quit_seen = 1'b0;
    halted = 1'b0;
    errors = 0;
    overfill_done = 1'b0;
    add_text("12.5 3.25+= 2 7-= 3 4*= 1 0/= 0 0/= += 1.23456 .5.7==\n");
    char_queue.push_back(8'hFF);
    char_queue.push_back(8'h00);
    while (char_queue.size() < 1100) begin
      pick = $urandom_range(99);
      if (!overfill_done && char_queue.size() > 400) begin
        // Overfill the stack, then drain it
        overfill_done = 1'b1;
        repeat (Depth + 2) add_text("1 ");
        repeat (Depth + 2) char_queue.push_back(pfe_pkg::ChEq);
      end else if (pick < 40) begin
        add_number();
        if ($urandom_range(3) != 0) char_queue.push_back(" ");
      end else if (pick < 65) begin
        add_operator();
      end else if (pick < 83) begin
        char_queue.push_back(pfe_pkg::ChEq);
      end else if (pick < 90) begin
        char_queue.push_back(pfe_pkg::ChNl);
      end else begin
        noise = 8'($urandom_range(255));
        char_queue.push_back(noise == pfe_pkg::ChHash ? pfe_pkg::ChDot : noise);
      end
    end
    // Goodbye, finish the line, then halted input
    add_text("5#1 2+=\nx9=#\n");
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    wait (char_queue.size() == 0 && !in_valid);
    wait (pending_results.size() == 0);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_char_code <= '0;
      chars_sent <= 0;
    end else if (!in_valid || in_ready) begin
      if (char_queue.size() != 0 &&
          ((chars_sent > 300 && chars_sent < 500) || $urandom_range(99) >= 20)) begin
        in_valid <= 1'b1;
        in_char_code <= char_queue.pop_front();
        chars_sent <= chars_sent + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result ready, with one long hold-off to back up the block
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && results_seen >= 150) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else begin
      out_ready <= (results_seen > 600 && results_seen < 800) || $urandom_range(99) >= 20;
    end
  end

  // Predict on each input beat, compare on each result beat
  always @(posedge clk) begin
    calc_result_t exp_r;
    if (!rst_n) begin
      results_seen <= 0;
    end else begin
      if (in_valid && in_ready) begin
        eval_char(in_char_code, exp_r);
        pending_results.push_back(exp_r);
      end
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (pending_results.size() == 0) begin
          $error("unexpected result beat: value %0h status %0d", out_value, out_status);
          errors++;
        end else begin
          exp_r = pending_results.pop_front();
          if (out_value !== exp_r.value) begin
            $error("value: expected %0h, got %0h", exp_r.value, out_value);
            errors++;
          end
          if (out_status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, out_status);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog
  initial begin
    #10ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
`default_nettype wire
